[hdl/swmc_pkg.sv]
// ----------------------------------------------------------------------------
// swmc_pkg
// Shared constants, codes and types of the sliding window mismatch counter.
// ----------------------------------------------------------------------------
package swmc_pkg;

	// Largest pattern held
	localparam int MaxPattern = 64;
	localparam int IdxW       = $clog2(MaxPattern);
	localparam int CntW       = $clog2(MaxPattern + 1);

	// Fixed field widths
	localparam int CfgW    = 7;
	localparam int RegIdxW = 1;
	localparam int CmdW    = 2;
	localparam int PidxW   = 6;
	localparam int SymW    = 8;
	localparam int CountW  = 7;
	localparam int PosW    = 32;

	// Command codes
	localparam logic [CmdW-1:0] CmdPattern = 2'd0;
	localparam logic [CmdW-1:0] CmdText    = 2'd1;
	localparam logic [CmdW-1:0] CmdRestart = 2'd2;

	// Register indexes
	localparam logic [RegIdxW-1:0] RegPatternLength = 1'd0;
	localparam logic [RegIdxW-1:0] RegMismatchLimit = 1'd1;

	// Register reset values
	localparam logic [CfgW-1:0] PatternLengthRst = 7'd1;
	localparam logic [CfgW-1:0] MismatchLimitRst = 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_EMIT
	} swmc_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic start;
		logic issue;
		logic emit;
	} swmc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_scan;
		logic last_issue;
		logic out_busy;
	} swmc_sts_t;

endpackage

[hdl/swmc_if.sv]
// ----------------------------------------------------------------------------
// swmc_in_if / swmc_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface swmc_in_if;
	logic                        valid;
	logic                        ready;
	logic [swmc_pkg::CmdW-1:0]   command;
	logic [swmc_pkg::PidxW-1:0]  pattern_index;
	logic [swmc_pkg::SymW-1:0]   symbol;

	modport source (output valid, output command, output pattern_index, output symbol,
		input ready);
	modport sink (input valid, input command, input pattern_index, input symbol,
		output ready);
endinterface

interface swmc_out_if;
	logic                        valid;
	logic                        ready;
	logic [swmc_pkg::CountW-1:0] mismatch_count;
	logic [swmc_pkg::PosW-1:0]   window_start;

	modport source (output valid, output mismatch_count, output window_start,
		input ready);
	modport sink (input valid, input mismatch_count, input window_start,
		output ready);
endinterface

[hdl/sliding_window_mismatch_counter_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_mismatch_counter_unit
// Counts pattern mismatches over the window ending at each text byte that completes a window.
// ----------------------------------------------------------------------------
// Pattern write, restart and unknown commands leave the block ready for
// the next item. A text byte that completes a window starts a scan: one
// pattern and one text memory read per position, then a compare and a
// result load; the block takes no new item until the result is loaded.
// Other text bytes also leave the block ready for the next item.
// A waiting result stalls the block only when the next result is ready.
// Reset clears control, fill count, position and registers; memories are not
// cleared and need no clearing pass.
module sliding_window_mismatch_counter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [swmc_pkg::RegIdxW-1:0] cfg_index,
	input  logic [swmc_pkg::CfgW-1:0]    cfg_wdata,
	swmc_in_if.sink                      in_ch,
	swmc_out_if.source                   out_ch
);

	swmc_pkg::swmc_cmd_t cmd;
	swmc_pkg::swmc_sts_t sts;
	logic                in_ready;

	assign in_ch.ready = in_ready;

	swmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swmc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.command        (in_ch.command),
		.pattern_index  (in_ch.pattern_index),
		.symbol         (in_ch.symbol),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.mismatch_count (out_ch.mismatch_count),
		.window_start   (out_ch.window_start)
	);

endmodule

[hdl/swmc_ctrl.sv]
// ----------------------------------------------------------------------------
// swmc_ctrl
// Sequencer: takes items, steps the compare scan and loads the result.
// ----------------------------------------------------------------------------
module swmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swmc_pkg::swmc_sts_t sts,
	output swmc_pkg::swmc_cmd_t cmd
);

	swmc_pkg::swmc_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swmc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			swmc_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.need_scan) begin
					cmd.start = 1'b1;
					state_d   = swmc_pkg::ST_READ;
				end
			end
			swmc_pkg::ST_READ: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = swmc_pkg::ST_LAST;
				end
			end
			swmc_pkg::ST_LAST: begin
				// final compare settles into the accumulator
				state_d = swmc_pkg::ST_EMIT;
			end
			swmc_pkg::ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = swmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swmc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/swmc_dp.sv]
// ----------------------------------------------------------------------------
// swmc_dp
// Pattern and text memories, position tracking, compare and result register.
// ----------------------------------------------------------------------------
module swmc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [swmc_pkg::RegIdxW-1:0]       cfg_index,
	input  logic [swmc_pkg::CfgW-1:0]          cfg_wdata,
	input  logic [swmc_pkg::CmdW-1:0]          command,
	input  logic [swmc_pkg::PidxW-1:0]         pattern_index,
	input  logic [swmc_pkg::SymW-1:0]          symbol,
	input  swmc_pkg::swmc_cmd_t                cmd,
	output swmc_pkg::swmc_sts_t                sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [swmc_pkg::CountW-1:0]        mismatch_count,
	output logic [swmc_pkg::PosW-1:0]          window_start
);

	localparam int IdxW = swmc_pkg::IdxW;
	localparam int CntW = swmc_pkg::CntW;
	localparam int CfgW = swmc_pkg::CfgW;
	localparam int SymW = swmc_pkg::SymW;
	localparam int PosW = swmc_pkg::PosW;

	logic [SymW-1:0] pat_mem [swmc_pkg::MaxPattern];
	logic [SymW-1:0] txt_mem [swmc_pkg::MaxPattern];

	logic [CfgW-1:0] len_cfg_q;
	logic [CfgW-1:0] limit_q;
	logic [IdxW-1:0] head_q;
	logic [CntW-1:0] fill_q;
	logic [PosW-1:0] pos_q;
	logic [IdxW-1:0] base_q;
	logic [IdxW-1:0] j_q;
	logic [CntW-1:0] acc_q;
	logic [PosW-1:0] win_start_q;
	logic [SymW-1:0] pat_rd_s1;
	logic [SymW-1:0] txt_rd_s1;
	logic            rd_valid_s1;
	logic            out_valid_q;
	logic [CntW-1:0] count_q;
	logic [PosW-1:0] start_q;

	logic [CntW-1:0] len;
	logic [IdxW-1:0] len_m1;
	logic [CfgW:0]   cap;
	logic [CntW-1:0] fill_next;
	logic [IdxW-1:0] head_next;
	logic            is_text;
	logic            is_pattern;
	logic            is_restart;
	logic            pidx_ok;

	// Clamp the pattern length into the supported range
	always_comb begin
		if (len_cfg_q == '0) begin
			len = CntW'(1);
		end else if (int'(len_cfg_q) > swmc_pkg::MaxPattern) begin
			len = CntW'(swmc_pkg::MaxPattern);
		end else begin
			len = CntW'(len_cfg_q);
		end
	end

	assign len_m1     = IdxW'(len - CntW'(1));
	assign cap        = {1'b0, limit_q} + (CfgW+1)'(1);
	assign is_text    = (command == swmc_pkg::CmdText);
	assign is_pattern = (command == swmc_pkg::CmdPattern);
	assign is_restart = (command == swmc_pkg::CmdRestart);
	assign pidx_ok    = (int'(pattern_index) < swmc_pkg::MaxPattern);
	assign head_next  = head_q + IdxW'(1);
	assign fill_next  = (int'(fill_q) < swmc_pkg::MaxPattern) ? fill_q + CntW'(1) : fill_q;

	assign sts.need_scan  = is_text && (fill_next >= len);
	assign sts.last_issue = (j_q == len_m1);
	assign sts.out_busy   = out_valid_q && !out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= swmc_pkg::PatternLengthRst;
			limit_q   <= swmc_pkg::MismatchLimitRst;
		end else if (cfg_we) begin
			case (cfg_index)
				swmc_pkg::RegPatternLength: len_cfg_q <= cfg_wdata;
				swmc_pkg::RegMismatchLimit: limit_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Text stream history: head, fill and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			pos_q  <= '0;
		end else if (cmd.accept) begin
			if (is_text) begin
				head_q <= head_next;
				fill_q <= fill_next;
				pos_q  <= pos_q + PosW'(1);
			end else if (is_restart) begin
				fill_q <= '0;
				pos_q  <= '0;
			end
		end
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (cmd.accept && is_pattern && pidx_ok) begin
			pat_mem[IdxW'(pattern_index)] <= symbol;
		end
		if (cmd.accept && is_text) begin
			txt_mem[head_next] <= symbol;
		end
	end

	// Registered memory reads, one pattern position per cycle
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			pat_rd_s1 <= pat_mem[j_q];
			txt_rd_s1 <= txt_mem[base_q + j_q];
		end
	end

	// Scan control: window base, index and result position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			j_q         <= '0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.start) begin
				j_q <= '0;
			end else if (cmd.issue) begin
				j_q <= j_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			base_q      <= head_next - len_m1;
			win_start_q <= pos_q - (PosW'(len) - PosW'(1));
		end
	end

	// Accumulate mismatches, saturating at the cutoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.start) begin
			acc_q <= '0;
		end else if (rd_valid_s1 && (pat_rd_s1 != txt_rd_s1) &&
				((CfgW+1)'(acc_q) < cap)) begin
			acc_q <= acc_q + CntW'(1);
		end
	end

	// Result register: load on emit, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			count_q <= acc_q;
			start_q <= win_start_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign mismatch_count = swmc_pkg::CountW'(count_q);
	assign window_start   = start_q;

endmodule

[hdl/swmc_checker.sv]
// ----------------------------------------------------------------------------
// swmc_checker
// Port-level checks of the mismatch counter, bound to the top level.
// ----------------------------------------------------------------------------
module swmc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [swmc_pkg::CmdW-1:0]   command,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [swmc_pkg::CountW-1:0] mismatch_count,
	input logic [swmc_pkg::PosW-1:0]   window_start
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mismatch_count) &&
		$stable(window_start))
		else $error("stalled result changed or dropped");

	// Count never exceeds the largest pattern
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(mismatch_count) <= swmc_pkg::MaxPattern))
		else $error("mismatch count out of range");

	// Non-text commands finish in their own cycle
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command != swmc_pkg::CmdText) |=> in_ready)
		else $error("block busy after a non-text transfer");

	// No result straight out of reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind sliding_window_mismatch_counter_unit swmc_checker u_swmc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.command        (in_ch.command),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.mismatch_count (out_ch.mismatch_count),
	.window_start   (out_ch.window_start)
);
